/* rtl/fdtns_pkg.sv */
// fdtns_pkg: token codes, result codes and shared types for the node name search
// used by fdtns_name_cmp and fdt_node_name_search; depends on nothing
`default_nettype none
package fdtns_pkg;

    localparam int WORD_W   = 32;
    localparam int IDX_W    = 30;
    localparam int SKIP_W   = 31;
    localparam int NPOS_W   = 5;
    localparam int TLEN_W   = 5;
    localparam int TBYTES   = 16;
    localparam int STATUS_W = 2;
    localparam int CIDX_W   = 2;
    localparam int CDATA_W  = 64;

    localparam logic [WORD_W-1:0] TOK_NODE_OPEN  = 32'h0000_0001;
    localparam logic [WORD_W-1:0] TOK_NODE_CLOSE = 32'h0000_0002;
    localparam logic [WORD_W-1:0] TOK_PROPERTY   = 32'h0000_0003;
    localparam logic [WORD_W-1:0] TOK_NOP        = 32'h0000_0004;
    localparam logic [WORD_W-1:0] TOK_END        = 32'h0000_0009;

    localparam logic [STATUS_W-1:0] ST_FOUND   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_END     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_UNKNOWN = 2'd2;

    localparam logic [CIDX_W-1:0] REG_STRUCT_BASE = 2'd0;
    localparam logic [CIDX_W-1:0] REG_TARGET_LOW  = 2'd1;
    localparam logic [CIDX_W-1:0] REG_TARGET_HIGH = 2'd2;
    localparam logic [CIDX_W-1:0] REG_TARGET_LEN  = 2'd3;

    typedef enum logic [5:0] {
        PH_TAG  = 6'b000001,
        PH_NAME = 6'b000010,
        PH_PLEN = 6'b000100,
        PH_POFF = 6'b001000,
        PH_SKIP = 6'b010000,
        PH_DONE = 6'b100000
    } phase_t;

    typedef struct packed {
        logic              nul_found;
        logic              match;
        logic              mismatch;
        logic [NPOS_W-1:0] pos;
    } name_res_t;

endpackage
`default_nettype wire

/* rtl/fdtns_name_cmp.sv */
// fdtns_name_cmp: compares the four name bytes of one structure word with the target
// depends on fdtns_pkg
`default_nettype none
module fdtns_name_cmp #(
    parameter int MAX_NAME_BYTES = 16
) (
    input  wire logic [fdtns_pkg::WORD_W-1:0] word,
    input  wire logic [fdtns_pkg::NPOS_W-1:0] pos_in,
    input  wire logic                         mismatch_in,
    input  wire logic [fdtns_pkg::CDATA_W-1:0] target_low,
    input  wire logic [fdtns_pkg::CDATA_W-1:0] target_high,
    input  wire logic [fdtns_pkg::TLEN_W-1:0] target_len,
    output fdtns_pkg::name_res_t              res
);

    logic [7:0] tbytes [fdtns_pkg::TBYTES];

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            tbytes[i]     = target_low[63-8*i -: 8];
            tbytes[i + 8] = target_high[63-8*i -: 8];
        end
    end

    always_comb
    begin
        logic                             done;
        logic                             mm;
        logic                             hit;
        logic [fdtns_pkg::NPOS_W-1:0]     pos;
        logic [7:0]                       b;
        done = 1'b0;
        mm   = mismatch_in;
        hit  = 1'b0;
        pos  = pos_in;
        for (int k = 0; k < 4; k++)
        begin
            b = word[31-8*k -: 8];
            if (!done)
            begin
                if (b == 8'd0)
                begin
                    done = 1'b1;
                    hit  = !mm && (pos == target_len);
                end
                else if (pos < fdtns_pkg::NPOS_W'(MAX_NAME_BYTES))
                begin
                    if (pos >= target_len || b != tbytes[pos[3:0]])
                        mm = 1'b1;
                    pos = pos + fdtns_pkg::NPOS_W'(1);
                end
                else
                begin
                    mm = 1'b1;
                end
            end
        end
        res.nul_found = done;
        res.match     = hit;
        res.mismatch  = mm;
        res.pos       = pos;
    end

endmodule
`default_nettype wire

/* rtl/fdt_node_name_search.sv */
// fdt_node_name_search: streaming node name search over a device tree structure block
// depends on fdtns_pkg and fdtns_name_cmp
//
// One 32-bit structure word is taken per cycle while the input does not stall. An accepted
// word sits in the input register while the token phase update and name byte compare run,
// and its result, if any, enters the result register as the word leaves it. Most words give
// no result; the first matching begin-node, an end token or an unknown tag gives one,
// after which words are dropped until a word with start_req set. The input stalls only
// while a result waits unaccepted and the input register is full. Configuration is
// always ready.
`default_nettype none
module fdt_node_name_search #(
    parameter int MAX_NAME_BYTES = 16
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [fdtns_pkg::WORD_W-1:0]      word,
    input  wire logic                              start_req,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic [fdtns_pkg::STATUS_W-1:0]         status,
    output logic [fdtns_pkg::WORD_W-1:0]           node_offset,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [fdtns_pkg::CIDX_W-1:0]      cfg_index,
    input  wire logic [fdtns_pkg::CDATA_W-1:0]     cfg_data
);

    logic [fdtns_pkg::WORD_W-1:0]   struct_base_reg;
    logic [fdtns_pkg::CDATA_W-1:0]  target_low_reg;
    logic [fdtns_pkg::CDATA_W-1:0]  target_high_reg;
    logic [fdtns_pkg::TLEN_W-1:0]   target_len_reg;

    logic                           s1_valid_reg;
    logic [fdtns_pkg::WORD_W-1:0]   s1_word_reg;
    logic                           s1_start_reg;

    fdtns_pkg::phase_t              phase_reg, phase_next, phase_cur;
    logic [fdtns_pkg::SKIP_W-1:0]   skip_reg, skip_next;
    logic [fdtns_pkg::NPOS_W-1:0]   name_pos_reg, name_pos_next;
    logic                           mismatch_reg, mismatch_next;
    logic [fdtns_pkg::IDX_W-1:0]    word_idx_reg, word_idx_next, word_idx_cur;
    logic [fdtns_pkg::IDX_W-1:0]    node_idx_reg, node_idx_next;

    logic                           out_valid_reg;
    logic [fdtns_pkg::STATUS_W-1:0] status_reg, status_next;
    logic [fdtns_pkg::WORD_W-1:0]   offset_reg, offset_next;

    logic                           advance;
    logic                           s1_fire;
    logic                           res_valid;
    logic [fdtns_pkg::IDX_W-1:0]    skip_dec;
    fdtns_pkg::name_res_t           name_res;

    assign cfg_ready   = 1'b1;
    assign advance     = !out_valid_reg || out_ready;
    assign in_ready    = !s1_valid_reg || advance;
    assign s1_fire     = s1_valid_reg && advance;
    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign node_offset = offset_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            struct_base_reg <= '0;
            target_low_reg  <= '0;
            target_high_reg <= '0;
            target_len_reg  <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                fdtns_pkg::REG_STRUCT_BASE: struct_base_reg <= cfg_data[31:0];
                fdtns_pkg::REG_TARGET_LOW:  target_low_reg  <= cfg_data;
                fdtns_pkg::REG_TARGET_HIGH: target_high_reg <= cfg_data;
                fdtns_pkg::REG_TARGET_LEN:  target_len_reg  <= cfg_data[4:0];
                default: ;
            endcase
        end
    end

    fdtns_name_cmp #(
        .MAX_NAME_BYTES (MAX_NAME_BYTES)
    ) u_name_cmp (
        .word        (s1_word_reg),
        .pos_in      (name_pos_reg),
        .mismatch_in (mismatch_reg),
        .target_low  (target_low_reg),
        .target_high (target_high_reg),
        .target_len  (target_len_reg),
        .res         (name_res)
    );

    assign skip_dec = skip_reg[fdtns_pkg::IDX_W-1:0] - fdtns_pkg::IDX_W'(1);

    always_comb
    begin
        phase_cur    = s1_start_reg ? fdtns_pkg::PH_TAG : phase_reg;
        word_idx_cur = s1_start_reg ? '0 : word_idx_reg;

        phase_next    = phase_cur;
        skip_next     = skip_reg;
        name_pos_next = name_pos_reg;
        mismatch_next = mismatch_reg;
        node_idx_next = node_idx_reg;
        word_idx_next = word_idx_cur + fdtns_pkg::IDX_W'(1);
        res_valid     = 1'b0;
        status_next   = fdtns_pkg::ST_FOUND;
        offset_next   = '0;

        unique case (phase_cur)
            fdtns_pkg::PH_TAG:
            begin
                priority if (s1_word_reg == fdtns_pkg::TOK_NODE_OPEN)
                begin
                    node_idx_next = word_idx_cur;
                    name_pos_next = '0;
                    mismatch_next = 1'b0;
                    phase_next    = fdtns_pkg::PH_NAME;
                end
                else if (s1_word_reg == fdtns_pkg::TOK_NODE_CLOSE ||
                         s1_word_reg == fdtns_pkg::TOK_NOP)
                begin
                    phase_next = fdtns_pkg::PH_TAG;
                end
                else if (s1_word_reg == fdtns_pkg::TOK_PROPERTY)
                begin
                    phase_next = fdtns_pkg::PH_PLEN;
                end
                else
                begin
                    res_valid   = 1'b1;
                    status_next = (s1_word_reg == fdtns_pkg::TOK_END) ?
                                  fdtns_pkg::ST_END : fdtns_pkg::ST_UNKNOWN;
                    phase_next  = fdtns_pkg::PH_DONE;
                end
            end
            fdtns_pkg::PH_NAME:
            begin
                name_pos_next = name_res.pos;
                mismatch_next = name_res.mismatch;
                if (name_res.nul_found)
                begin
                    if (name_res.match)
                    begin
                        res_valid   = 1'b1;
                        status_next = fdtns_pkg::ST_FOUND;
                        offset_next = struct_base_reg + {node_idx_reg, 2'b00};
                        phase_next  = fdtns_pkg::PH_DONE;
                    end
                    else
                    begin
                        phase_next = fdtns_pkg::PH_TAG;
                    end
                end
            end
            fdtns_pkg::PH_PLEN:
            begin
                // data length rounded up to whole words
                skip_next  = {1'b0, s1_word_reg[31:2]} + fdtns_pkg::SKIP_W'(|s1_word_reg[1:0]);
                phase_next = fdtns_pkg::PH_POFF;
            end
            fdtns_pkg::PH_POFF:
            begin
                phase_next = (skip_reg == '0) ? fdtns_pkg::PH_TAG : fdtns_pkg::PH_SKIP;
            end
            fdtns_pkg::PH_SKIP:
            begin
                skip_next = {1'b0, skip_dec};
                if (skip_dec == '0)
                    phase_next = fdtns_pkg::PH_TAG;
            end
            default:
            begin
                phase_next = fdtns_pkg::PH_DONE;
            end
        endcase
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_word_reg  <= word;
            s1_start_reg <= start_req;
        end
    end

    // walk state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= fdtns_pkg::PH_TAG;
            skip_reg     <= '0;
            name_pos_reg <= '0;
            mismatch_reg <= 1'b0;
            word_idx_reg <= '0;
            node_idx_reg <= '0;
        end
        else if (s1_fire)
        begin
            phase_reg    <= phase_next;
            skip_reg     <= skip_next;
            name_pos_reg <= name_pos_next;
            mismatch_reg <= mismatch_next;
            word_idx_reg <= word_idx_next;
            node_idx_reg <= node_idx_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= s1_fire && res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && res_valid)
        begin
            status_reg <= status_next;
            offset_reg <= offset_next;
        end
    end

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (status_reg == fdtns_pkg::ST_FOUND ||
                           status_reg == fdtns_pkg::ST_END ||
                           status_reg == fdtns_pkg::ST_UNKNOWN))
        else $error("result status out of range");

    a_offset_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg != fdtns_pkg::ST_FOUND) |-> offset_reg == '0)
        else $error("nonzero offset on end or unknown result");

    a_done_after_result: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && res_valid) |=> phase_reg == fdtns_pkg::PH_DONE)
        else $error("walk did not stop after a result");

    a_quiet_when_done: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && phase_reg == fdtns_pkg::PH_DONE && !s1_start_reg) |-> !res_valid)
        else $error("result produced after search finished");

    a_name_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        name_pos_reg <= fdtns_pkg::NPOS_W'(MAX_NAME_BYTES))
        else $error("name position beyond limit");

endmodule
`default_nettype wire
